FILE: hw/rtl/gsc_pkg.sv
// shared types and constants for the geometric segment cost block
`default_nettype none
package gsc_pkg;

    // fraction bits of the internal log2 result
    localparam int LOG_FB = 28;
    // ln 2 in Q0.30, rounded
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [62:0] MAX63 = {63{1'b1}};

    typedef enum logic [1:0] {
        LOG_SEL_SUM  = 2'd0,
        LOG_SEL_LEN  = 2'd1,
        LOG_SEL_DIFF = 2'd2
    } log_sel_t;

    typedef struct packed {
        logic     load;
        logic     log_start;
        log_sel_t log_sel;
        logic     fmul;
        logic     fstore;
        logic     term;
        logic     acc;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic log_done;
        logic skip;
        logic last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gsc_log.sv
// iterative fixed-point natural log unit, one squaring step per log2 fraction bit
`default_nettype none
module gsc_log #(
    parameter int XW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic [XW-1:0]                         x,
    output logic                                       done,
    output logic [$clog2(XW)+FRAC_BITS-1:0]            ln
);
    localparam int KW  = $clog2(XW);
    localparam int LW  = KW + FRAC_BITS;
    localparam int L2W = KW + gsc_pkg::LOG_FB;
    localparam int PW  = KW + 58;
    localparam int SH  = 58 - FRAC_BITS;

    typedef enum logic [2:0] {
        L_IDLE, L_NORM, L_SQ, L_UPD, L_SCALE, L_ROUND
    } lstate_t;

    lstate_t                 state_reg;
    logic                    done_reg;
    logic [XW-1:0]           x_reg;
    logic [31:0]             m_reg;
    logic [63:0]             p_reg;
    logic [KW-1:0]           k_reg;
    logic [gsc_pkg::LOG_FB-1:0] frac_reg;
    logic [4:0]              cnt_reg;
    logic [PW-1:0]           sp_reg;
    logic [LW-1:0]           ln_reg;

    logic [KW-1:0]           k_next;
    logic [31:0]             m_next;
    logic [71:0]             x_ext;
    logic [32:0]             q;
    logic [L2W-1:0]          log2_val;
    logic [PW:0]             rnd;

    always_comb begin
        k_next = '0;
        for (int i = 0; i < XW; i++) begin
            if (x_reg[i]) begin
                k_next = KW'(i);
            end
        end
        x_ext = 72'(x_reg);
        if (32'(k_next) >= 32'd31) begin
            m_next = 32'(x_ext >> (32'(k_next) - 32'd31));
        end else begin
            m_next = 32'(x_ext << (32'd31 - 32'(k_next)));
        end
        q        = p_reg[63:31];
        log2_val = {k_reg, frac_reg};
        rnd      = (PW+1)'(sp_reg) + ((PW+1)'(1) << (SH - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        x_reg     <= x;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (x_reg == '0) begin
                        ln_reg    <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end else begin
                        k_reg     <= k_next;
                        m_reg     <= m_next;
                        frac_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= L_SQ;
                    end
                end
                L_SQ: begin
                    p_reg     <= 64'(m_reg) * 64'(m_reg);
                    state_reg <= L_UPD;
                end
                L_UPD: begin
                    // squared mantissa past 2: emit a one and renormalise
                    if (q[32]) begin
                        m_reg    <= q[32:1];
                        frac_reg <= {frac_reg[gsc_pkg::LOG_FB-2:0], 1'b1};
                    end else begin
                        m_reg    <= q[31:0];
                        frac_reg <= {frac_reg[gsc_pkg::LOG_FB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(gsc_pkg::LOG_FB - 1)) begin
                        state_reg <= L_SCALE;
                    end else begin
                        state_reg <= L_SQ;
                    end
                end
                L_SCALE: begin
                    sp_reg    <= PW'(log2_val) * PW'(gsc_pkg::LN2_Q30);
                    state_reg <= L_ROUND;
                end
                L_ROUND: begin
                    ln_reg    <= rnd[SH +: LW];
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign ln   = ln_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/gsc_dp.sv
// datapath: operand registers, x ln x products, term, accumulator and result register
`default_nettype none
module gsc_dp #(
    parameter int SUM_BITS  = 32,
    parameter int LEN_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire gsc_pkg::cmd_t cmd,
    output gsc_pkg::sts_t      sts,
    input  wire logic [31:0]   in_sum,
    input  wire logic [15:0]   in_len,
    input  wire logic          in_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [62:0]        out_cost
);
    localparam int XW = (SUM_BITS > LEN_BITS) ? SUM_BITS : LEN_BITS;
    localparam int KW = $clog2(XW);
    localparam int LW = KW + FRAC_BITS;
    localparam int FW = XW + LW;
    localparam int TW = (FW + 1 > 64) ? FW + 1 : 64;

    logic [XW-1:0] d_reg, l_reg;
    logic          last_reg;
    logic [FW-1:0] fprod_reg, fa_reg;
    logic [FW:0]   fs_reg;
    logic [62:0]   term_reg, acc_reg, out_reg;
    logic          out_valid_reg;

    logic [71:0]   sum_ext, len_ext;
    logic [XW-1:0] d_in, l_in, dl, x_sel;
    logic          log_done;
    logic [LW-1:0] ln;
    logic [TW-1:0] a_ext, s_ext, diff;
    logic [62:0]   term_next, acc_sat;
    logic [63:0]   acc_sum;

    gsc_log #(.XW(XW), .FRAC_BITS(FRAC_BITS)) u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.log_start),
        .x       (x_sel),
        .done    (log_done),
        .ln      (ln)
    );

    always_comb begin
        sum_ext = 72'(in_sum);
        len_ext = 72'(in_len);
        d_in    = XW'(sum_ext[SUM_BITS-1:0]);
        l_in    = XW'(len_ext[LEN_BITS-1:0]);
        dl      = d_reg - l_reg;
        case (cmd.log_sel)
            gsc_pkg::LOG_SEL_SUM:  x_sel = d_reg;
            gsc_pkg::LOG_SEL_LEN:  x_sel = l_reg;
            gsc_pkg::LOG_SEL_DIFF: x_sel = dl;
            default:               x_sel = d_reg;
        endcase
        a_ext = TW'(fa_reg);
        s_ext = TW'(fs_reg);
        diff  = a_ext - s_ext;
        if ((d_reg <= l_reg) || (a_ext < s_ext)) begin
            term_next = '0;
        end else if (diff > TW'(gsc_pkg::MAX63)) begin
            term_next = gsc_pkg::MAX63;
        end else begin
            term_next = diff[62:0];
        end
        acc_sum = 64'(acc_reg) + 64'(term_reg);
        acc_sat = acc_sum[63] ? gsc_pkg::MAX63 : acc_sum[62:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                d_reg    <= d_in;
                l_reg    <= l_in;
                last_reg <= in_last;
            end
            if (cmd.fmul) begin
                fprod_reg <= FW'(x_sel) * FW'(ln);
            end
            if (cmd.fstore) begin
                case (cmd.log_sel)
                    gsc_pkg::LOG_SEL_SUM:  fa_reg <= fprod_reg;
                    gsc_pkg::LOG_SEL_LEN:  fs_reg <= (FW+1)'(fprod_reg);
                    gsc_pkg::LOG_SEL_DIFF: fs_reg <= fs_reg + (FW+1)'(fprod_reg);
                    default:               fa_reg <= fprod_reg;
                endcase
            end
            if (cmd.term) begin
                term_reg <= term_next;
            end
            if (cmd.acc) begin
                if (cmd.emit) begin
                    out_reg <= acc_sat;
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_sat;
                end
            end
            if (cmd.acc && cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.log_done = log_done;
    assign sts.skip     = (d_reg <= l_reg);
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_cost     = out_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/gsc_ctrl.sv
// controller: sequences the three log and product passes per dimension, or none for a skipped one
`default_nettype none
module gsc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    output gsc_pkg::cmd_t      cmd,
    input  wire gsc_pkg::sts_t sts
);
    typedef enum logic [2:0] {
        C_IDLE, C_START, C_WAIT, C_FMUL, C_FSTORE, C_TERM, C_ACC
    } cstate_t;

    cstate_t           state_reg;
    gsc_pkg::log_sel_t sel_reg;

    always_comb begin
        in_ready      = (state_reg == C_IDLE);
        cmd           = '0;
        cmd.log_sel   = sel_reg;
        cmd.load      = in_ready && in_valid;
        cmd.log_start = (state_reg == C_START) && !sts.skip;
        cmd.fmul      = (state_reg == C_FMUL);
        cmd.fstore    = (state_reg == C_FSTORE);
        cmd.term      = (state_reg == C_TERM);
        cmd.acc       = (state_reg == C_ACC) && (!sts.last || sts.out_free);
        cmd.emit      = (state_reg == C_ACC) && sts.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            sel_reg   <= gsc_pkg::LOG_SEL_SUM;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (in_valid) begin
                        sel_reg   <= gsc_pkg::LOG_SEL_SUM;
                        state_reg <= C_START;
                    end
                end
                C_START: begin
                    // dimension with sum not above length adds nothing
                    state_reg <= sts.skip ? C_TERM : C_WAIT;
                end
                C_WAIT: begin
                    if (sts.log_done) begin
                        state_reg <= C_FMUL;
                    end
                end
                C_FMUL: state_reg <= C_FSTORE;
                C_FSTORE: begin
                    case (sel_reg)
                        gsc_pkg::LOG_SEL_SUM: begin
                            sel_reg   <= gsc_pkg::LOG_SEL_LEN;
                            state_reg <= C_START;
                        end
                        gsc_pkg::LOG_SEL_LEN: begin
                            sel_reg   <= gsc_pkg::LOG_SEL_DIFF;
                            state_reg <= C_START;
                        end
                        default: state_reg <= C_TERM;
                    endcase
                end
                C_TERM: state_reg <= C_ACC;
                C_ACC: begin
                    if (!sts.last || sts.out_free) begin
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/geometric_segment_cost.sv
// a dimension with sum above length runs three log passes from input transfer to result, and
// goes straight to the term and accumulate states otherwise; the next input is taken back in idle
// one dimension at a time; bound by the shared log unit, which squares once per log2
// fraction bit (28 bits) for each of its three logs
// the result register frees the input side while a total waits for transfer
// reset (synchronous, active low) clears the accumulator and all control state
`default_nettype none
module geometric_segment_cost #(
    parameter int SUM_BITS  = 32,
    parameter int LEN_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_segment_sum,
    input  wire logic [15:0] s_segment_length,
    input  wire logic        s_last_dimension,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [62:0]      m_segment_cost
);
    gsc_pkg::cmd_t cmd;
    gsc_pkg::sts_t sts;

    gsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gsc_dp #(
        .SUM_BITS  (SUM_BITS),
        .LEN_BITS  (LEN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_sum    (s_segment_sum),
        .in_len    (s_segment_length),
        .in_last   (s_last_dimension),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_cost  (m_segment_cost)
    );
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the geometric segment cost block
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 550;
    localparam longint CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_segment_sum;
    logic [15:0] s_segment_length;
    logic        s_last_dimension;
    logic        m_valid;
    logic        m_ready;
    logic [62:0] m_segment_cost;

    geometric_segment_cost u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_segment_sum(s_segment_sum), .s_segment_length(s_segment_length),
        .s_last_dimension(s_last_dimension),
        .m_valid(m_valid), .m_ready(m_ready), .m_segment_cost(m_segment_cost)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    logic [62:0] running_cost;
    logic [62:0] cost_queue[$];
    int          error_count;
    longint      cycle_count;
    bit          calm;

    // log2 in Q.28 by repeated squaring of the mantissa
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int          k;
        logic [63:0] m;
        logic [63:0] frac;
        k = 0;
        frac = 0;
        for (int i = 0; i < 64; i++)
            if (x[i]) k = i;
        if (k >= 31) m = x >> (k - 31);
        else m = x << (31 - k);
        m = m & 64'hFFFF_FFFF;
        for (int i = 0; i < gsc_pkg::LOG_FB; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (64'(k) << gsc_pkg::LOG_FB) | frac;
    endfunction

    function automatic logic [127:0] x_ln_x(input logic [63:0] x);
        logic [63:0] ln;
        int          sh;
        sh = gsc_pkg::LOG_FB + 30 - FRAC;
        if (x == 0) return 128'd0;
        ln = (log2_fixed(x) * 64'(gsc_pkg::LN2_Q30) + (64'd1 << (sh - 1))) >> sh;
        return 128'(x) * 128'(ln);
    endfunction

    function automatic logic [62:0] dimension_cost(input logic [31:0] d, input logic [15:0] l);
        logic [127:0] a;
        logic [127:0] s;
        logic [127:0] r;
        if (64'(d) <= 64'(l)) return 63'd0;
        a = x_ln_x(64'(d));
        s = x_ln_x(64'(l)) + x_ln_x(64'(d) - 64'(l));
        if (a < s) return 63'd0;
        r = a - s;
        if (r > 128'(gsc_pkg::MAX63)) return gsc_pkg::MAX63;
        return r[62:0];
    endfunction

    // accumulate one accepted dimension; queue the total on the last one
    task automatic predict_dimension(input logic [31:0] d, input logic [15:0] l, input logic last);
        logic [63:0] s;
        s = 64'(running_cost) + 64'(dimension_cost(d, l));
        if (s > 64'(gsc_pkg::MAX63)) s = 64'(gsc_pkg::MAX63);
        running_cost = s[62:0];
        if (last) begin
            cost_queue.push_back(running_cost);
            running_cost = '0;
        end
    endtask

    task automatic report_mismatch(input logic [62:0] got, input logic [62:0] want);
        $display("mismatch: segment_cost got %0d want %0d", got, want);
        error_count++;
    endtask

    // directed rows: sum, length, last, typed expectation where obvious
    typedef struct {
        logic [31:0] sum;
        logic [15:0] len;
        logic        last;
        bit          has_want;
        logic [62:0] want;
    } stim_row_t;

    stim_row_t rows[$];
    logic [62:0] typed_queue[$];
    bit          typed_flag[$];

    always @(posedge aclk) begin
        logic [62:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (cost_queue.size() == 0) begin
                $display("unexpected segment_cost %0d", m_segment_cost);
                error_count++;
            end else begin
                want = cost_queue.pop_front();
                if (m_segment_cost !== want) report_mismatch(m_segment_cost, want);
                if (typed_flag.size() > 0) begin
                    if (typed_flag.pop_front()) begin
                        want = typed_queue.pop_front();
                        if (m_segment_cost !== want) report_mismatch(m_segment_cost, want);
                    end
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_dimension(input logic [31:0] d, input logic [15:0] l, input logic last);
        while (!calm && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_segment_sum <= d;
        s_segment_length <= l;
        s_last_dimension <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_dimension(d, l, last);
    endtask

    function automatic logic [31:0] random_sum(input logic [15:0] l);
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'(l) + $urandom_range(3);
            2: return $urandom_range(65535);
            3: return 32'(l) * $urandom_range(1, 40);
            default: return $urandom_range(300);
        endcase
    endfunction

    initial begin
        logic [15:0] l;
        int          burst;
        int          sent;
        error_count = 0;
        cycle_count = 0;
        running_cost = '0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_segment_sum = '0;
        s_segment_length = '0;
        s_last_dimension = 1'b0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{32'd0, 16'd1, 1'b1, 1'b1, 63'd0});
        rows.push_back('{32'd5, 16'd5, 1'b1, 1'b1, 63'd0});
        rows.push_back('{32'd7, 16'd0, 1'b1, 1'b1, 63'd0});
        rows.push_back('{32'd1, 16'd65535, 1'b1, 1'b1, 63'd0});
        rows.push_back('{32'd2, 16'd1, 1'b1, 1'b0, 63'd0});
        rows.push_back('{32'd3, 16'd1, 1'b0, 1'b0, 63'd0});
        rows.push_back('{32'd100, 16'd7, 1'b1, 1'b0, 63'd0});
        rows.push_back('{32'hFFFF_FFFF, 16'd1, 1'b1, 1'b0, 63'd0});
        rows.push_back('{32'hFFFF_FFFF, 16'd65535, 1'b1, 1'b0, 63'd0});
        rows.push_back('{32'h8000_0000, 16'h8000, 1'b1, 1'b0, 63'd0});
        rows.push_back('{32'h5555_5555, 16'h5555, 1'b0, 1'b0, 63'd0});
        rows.push_back('{32'hAAAA_AAAA, 16'hAAAA, 1'b1, 1'b0, 63'd0});
        rows.push_back('{32'd65536, 16'd65535, 1'b1, 1'b0, 63'd0});
        for (int i = 0; i < rows.size(); i++) begin
            if (rows[i].last) begin
                typed_flag.push_back(rows[i].has_want);
                if (rows[i].has_want) typed_queue.push_back(rows[i].want);
            end
        end
        // directed rows, checked by the predictor and, where given, the typed expectation
        for (int i = 0; i < rows.size(); i++)
            send_dimension(rows[i].sum, rows[i].len, rows[i].last);

        sent = 0;
        while (sent < N_RANDOM) begin
            calm = (sent >= 200 && sent < 280);
            burst = $urandom_range(1, 4);
            for (int j = 0; j < burst; j++) begin
                l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200));
                send_dimension(random_sum(l), l, j == burst - 1);
                sent++;
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (cost_queue.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
